>>> sv/vmm_pkg.sv
package vmm_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 5;
	localparam int LANES  = 8;
	localparam int LANE_W = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} vmm_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic emit;
	} vmm_cmd_t;

	typedef struct packed {
		logic act_ok;
		logic last_row;
		logic pipe_busy;
		logic out_free;
	} vmm_status_t;

endpackage

>>> sv/vmm_ram.sv
module vmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> sv/vmm_ctrl.sv
module vmm_ctrl import vmm_pkg::*; #(
	parameter int OUT_LEN = 32,
	localparam int GROUPS = (OUT_LEN + LANES - 1) / LANES,
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	localparam int CW = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  vmm_status_t st,
	output vmm_cmd_t    cmd,
	output logic [GW-1:0] grp,
	output logic [CW-1:0] col
);

	vmm_state_t state_q, state_d;
	logic [GW-1:0] grp_q;
	logic [CW-1:0] col_q;
	logic grp_last, col_last;

	assign grp_last = (grp_q == GW'(GROUPS - 1));
	assign col_last = (col_q == CW'(OUT_LEN - 1));
	assign grp = grp_q;
	assign col = col_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (valid && st.act_ok) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (grp_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.pipe_busy) begin
					state_d = st.last_row ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (st.out_free && col_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				stall = 1'b0;
				cmd.accept = valid;
			end
			ST_MAC: cmd.issue = 1'b1;
			ST_DRAIN: ;
			ST_EMIT: cmd.emit = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q <= '0;
			col_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.issue) begin
				grp_q <= grp_last ? '0 : grp_q + 1'b1;
			end
			if (cmd.emit) begin
				col_q <= col_last ? '0 : col_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/vmm_datapath.sv
module vmm_datapath import vmm_pkg::*; #(
	parameter int IN_LEN = 32,
	parameter int OUT_LEN = 32,
	localparam int GROUPS = (OUT_LEN + LANES - 1) / LANES,
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	localparam int CW = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1,
	localparam int DEPTH = IN_LEN * GROUPS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     kind,
	input  logic [IDX_W-1:0]         row,
	input  logic [IDX_W-1:0]         col,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [IDX_W-1:0]         out_index,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     out_last,
	input  vmm_cmd_t                 cmd,
	input  logic [GW-1:0]            grp,
	input  logic [CW-1:0]            ocol,
	output vmm_status_t              st
);

	logic [DATA_W-1:0] act_q;
	logic [IDX_W-1:0]  act_row_q;
	logic              v_s1, v_s2;
	logic              wr_ok, wr_en;
	logic [AW-1:0]     wr_addr, rd_addr, ram_addr;
	logic [LANE_W-1:0] wr_lane, out_lane;
	logic              ocol_last;
	logic [DATA_W-1:0] rdata [LANES];
	logic [DATA_W-1:0] prod_s2 [LANES];
	logic [DATA_W-1:0] acc_q [LANES][GROUPS];
	logic              out_valid_q, out_last_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [DATA_W-1:0] out_value_q;

	assign wr_ok = (int'(row) < IN_LEN) && (int'(col) < OUT_LEN);
	assign wr_en = cmd.accept && !kind && wr_ok;
	assign wr_lane = col[LANE_W-1:0];
	assign wr_addr = AW'(int'(row) * GROUPS + int'(col[IDX_W-1:LANE_W]));
	assign rd_addr = AW'(int'(act_row_q) * GROUPS + int'(grp));
	assign ram_addr = cmd.issue ? rd_addr : wr_addr;
	assign out_lane = LANE_W'(ocol);
	assign ocol_last = (ocol == CW'(OUT_LEN - 1));

	assign st.act_ok = kind && (int'(row) < IN_LEN);
	assign st.last_row = (int'(act_row_q) == IN_LEN - 1);
	assign st.pipe_busy = v_s1 || v_s2;
	assign st.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.accept && kind) begin
			act_q <= value;
			act_row_q <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// One weight bank and one accumulator ring per lane; lane l owns columns l, l+8, ...
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic rot;
		logic [DATA_W-1:0] nxt;

		vmm_ram #(
			.WIDTH(DATA_W),
			.DEPTH(DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (wr_en && (wr_lane == LANE_W'(l))),
			.addr (ram_addr),
			.wdata(value),
			.rdata(rdata[l])
		);

		always_ff @(posedge clk) begin
			if (v_s1) begin
				prod_s2[l] <= act_q * rdata[l];
			end
		end

		// Emit reads the ring heads; after the last column of a group every lane pushes zero.
		assign rot = v_s2 || (cmd.emit && ((out_lane == LANE_W'(LANES - 1)) || ocol_last));
		assign nxt = v_s2 ? acc_q[l][0] + prod_s2[l] : '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < GROUPS; i++) begin
					acc_q[l][i] <= '0;
				end
			end else if (rot) begin
				for (int i = 0; i < GROUPS - 1; i++) begin
					acc_q[l][i] <= acc_q[l][i + 1];
				end
				acc_q[l][GROUPS - 1] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= IDX_W'(ocol);
			out_value_q <= acc_q[out_lane][0];
			out_last_q <= ocol_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign out_last = out_last_q;

endmodule

>>> sv/vector_matrix_multiply_int32.sv
// Signed 32-bit vector times stored IN_LEN x OUT_LEN matrix, wrapping modulo 2^32. A transaction
// with kind 0 writes one weight (row, col); out-of-range addresses are dropped. A
// transaction with kind 1 adds value times weight row "row" into OUT_LEN accumulators using eight
// multiply-accumulate lanes, one column group per cycle from eight single-port weight banks. The
// activation for row IN_LEN-1 is followed by OUT_LEN results in column order, one per cycle while
// out_stall is low, the final one flagged by out_last; the accumulators are cleared as they are read
// out. Weights must be written before they are used; the weight store has no reset.
module vector_matrix_multiply_int32 import vmm_pkg::*; #(
	parameter int IN_LEN = 32,
	parameter int OUT_LEN = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     stall,
	input  logic                     kind,
	input  logic [IDX_W-1:0]         row,
	input  logic [IDX_W-1:0]         col,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         out_index,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     out_last
);

	localparam int GROUPS = (OUT_LEN + LANES - 1) / LANES;
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CW = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1;

	vmm_cmd_t    cmd;
	vmm_status_t st;
	logic [GW-1:0] grp;
	logic [CW-1:0] ocol;

	vmm_ctrl #(
		.OUT_LEN(OUT_LEN)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid),
		.stall (stall),
		.st    (st),
		.cmd   (cmd),
		.grp   (grp),
		.col   (ocol)
	);

	vmm_datapath #(
		.IN_LEN (IN_LEN),
		.OUT_LEN(OUT_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (kind),
		.row      (row),
		.col      (col),
		.value    (value),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_index(out_index),
		.out_value(out_value),
		.out_last (out_last),
		.cmd      (cmd),
		.grp      (grp),
		.ocol     (ocol),
		.st       (st)
	);

endmodule

>>> sv/vmm_checker.sv
module vmm_checker import vmm_pkg::*; #(
	parameter int OUT_LEN = 32
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [IDX_W-1:0]         out_index,
	input logic signed [DATA_W-1:0] out_value,
	input logic                     out_last
);

	// The final result always carries the last column index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_index == IDX_W'(OUT_LEN - 1))
		else $error("out_last on a column other than the last");

	// A vector streams without gaps once the receiver takes results.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_last |=> out_valid)
		else $error("gap inside an output vector");

	// No input transaction while an output vector is still being read out.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> stall)
		else $error("input accepted during vector readout");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_index)
			&& $stable(out_last))
		else $error("stalled result changed");

endmodule

bind vector_matrix_multiply_int32 vmm_checker #(
	.OUT_LEN(OUT_LEN)
) u_vmm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.stall    (stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_index(out_index),
	.out_value(out_value),
	.out_last (out_last)
);

>>> verif/tb_vector_matrix_multiply_int32.sv
`timescale 1ns / 100ps

module tb_vector_matrix_multiply_int32 import vmm_pkg::*;;

	localparam int IN_LEN      = 32;
	localparam int OUT_LEN     = 32;
	localparam int RANDOM_ITEMS = 150;
	localparam int QUIET_AFTER = 120;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;
	localparam int NUM_STEPS   = 22;

	localparam logic KIND_WEIGHT = 1'b0;
	localparam logic KIND_ACT    = 1'b1;

	typedef enum logic [1:0] {
		OP_WEIGHT,
		OP_ROW_FILL,
		OP_ACT
	} step_op_t;

	typedef struct packed {
		step_op_t                op;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic [DATA_W-1:0]       value;
		logic                    fixed;
		logic [DATA_W-1:0]       fixed_value;
	} layer_step_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
		logic              last;
	} dot_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     valid = 1'b0;
	logic                     stall;
	logic                     kind = KIND_WEIGHT;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [IDX_W-1:0]         out_index;
	logic signed [DATA_W-1:0] out_value;
	logic                     out_last;

	logic [DATA_W-1:0]  weight_mem [IN_LEN][OUT_LEN];
	logic [OUT_LEN-1:0] row_written [IN_LEN];
	logic [DATA_W-1:0]  accum [OUT_LEN];
	dot_result_t        dot_products_due [$];
	dot_result_t        due;

	int  failures = 0;
	int  item_count = 0;
	int  results_checked = 0;
	int  vectors_seen = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;

	// extremes, wrap cases, repeated and skipped rows, weight update mid-vector
	layer_step_t layer_steps [NUM_STEPS] = '{
		'{OP_ROW_FILL, 5'd31, 5'd0,  32'h0000_0001, 1'b0, 32'h0},
		'{OP_ACT,      5'd31, 5'd0,  32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
		'{OP_ACT,      5'd31, 5'd31, 32'h8000_0000, 1'b1, 32'h8000_0000},
		'{OP_ROW_FILL, 5'd31, 5'd0,  32'hffff_ffff, 1'b0, 32'h0},
		'{OP_ACT,      5'd31, 5'd0,  32'h8000_0000, 1'b1, 32'h8000_0000},
		'{OP_ACT,      5'd31, 5'd0,  32'h0000_0001, 1'b1, 32'hffff_ffff},
		'{OP_ROW_FILL, 5'd0,  5'd0,  32'h7fff_ffff, 1'b0, 32'h0},
		'{OP_ACT,      5'd0,  5'd0,  32'h7fff_ffff, 1'b0, 32'h0},
		'{OP_ACT,      5'd0,  5'd31, 32'h0000_0002, 1'b0, 32'h0},
		'{OP_ACT,      5'd31, 5'd0,  32'h0000_0000, 1'b1, 32'hffff_ffff},
		'{OP_ROW_FILL, 5'd5,  5'd0,  32'h0000_0000, 1'b0, 32'h0},
		'{OP_WEIGHT,   5'd5,  5'd0,  32'h8000_0000, 1'b0, 32'h0},
		'{OP_WEIGHT,   5'd5,  5'd31, 32'h7fff_ffff, 1'b0, 32'h0},
		'{OP_WEIGHT,   5'd5,  5'd21, 32'h5555_5555, 1'b0, 32'h0},
		'{OP_WEIGHT,   5'd5,  5'd10, 32'haaaa_aaaa, 1'b0, 32'h0},
		'{OP_ACT,      5'd5,  5'd0,  32'hffff_ffff, 1'b0, 32'h0},
		'{OP_ACT,      5'd31, 5'd0,  32'h0000_0003, 1'b0, 32'h0},
		'{OP_ACT,      5'd5,  5'd0,  32'h0000_0007, 1'b0, 32'h0},
		'{OP_WEIGHT,   5'd5,  5'd10, 32'h1234_5678, 1'b0, 32'h0},
		'{OP_ACT,      5'd5,  5'd0,  32'hffff_fffd, 1'b0, 32'h0},
		'{OP_ACT,      5'd0,  5'd0,  32'h8000_0000, 1'b0, 32'h0},
		'{OP_ACT,      5'd31, 5'd0,  32'h8000_0000, 1'b0, 32'h0}
	};

	vector_matrix_multiply_int32 #(
		.IN_LEN(IN_LEN),
		.OUT_LEN(OUT_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.stall(stall),
		.kind(kind),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_index(out_index),
		.out_value(out_value),
		.out_last(out_last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit row_full(int r);
		return &row_written[r];
	endfunction

	// Store one weight or fold one activation element into the running dot products; row IN_LEN-1 queues the results.
	task automatic update_dot_products(input logic k, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
			input logic fixed, input logic [DATA_W-1:0] fixed_value);
		dot_result_t res;
		int j;
		if (k == KIND_WEIGHT) begin
			weight_mem[r][c] = v;
			row_written[r][c] = 1'b1;
		end else begin
			for (j = 0; j < OUT_LEN; j++)
				accum[j] = accum[j] + v * weight_mem[r][j];
			if (r == IN_LEN - 1) begin
				for (j = 0; j < OUT_LEN; j++) begin
					res.index = j[IDX_W-1:0];
					res.value = fixed ? fixed_value : accum[j];
					res.last  = (j == OUT_LEN - 1);
					dot_products_due.push_back(res);
					accum[j] = '0;
				end
			end
		end
	endtask

	// Called right after a posedge; returns at the edge that accepted the transaction.
	task automatic send_item(input logic k, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
			input logic fixed, input logic [DATA_W-1:0] fixed_value);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		kind  <= k;
		row   <= r;
		col   <= c;
		value <= v;
		do @(posedge clk); while (stall);
		update_dot_products(k, r, c, v, fixed, fixed_value);
		item_count++;
	endtask

	task automatic fill_row(input logic [IDX_W-1:0] r, input bit random_values,
			input logic [DATA_W-1:0] v);
		int c;
		for (c = 0; c < OUT_LEN; c++)
			send_item(KIND_WEIGHT, r, c[IDX_W-1:0], random_values ? rand_word() : v, 1'b0, '0);
	endtask

	// Receiver side: random stall bursts, none during the quiet tail.
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (dot_products_due.size() == 0) begin
				$display("%0t: unexpected result: index %0d value %h last %b", $time,
					out_index, out_value, out_last);
				failures++;
			end else begin
				due = dot_products_due.pop_front();
				if (out_index !== due.index) begin
					$display("%0t: out_index mismatch: expected %0d, actual %0d", $time,
						due.index, out_index);
					failures++;
				end
				if (out_value !== due.value) begin
					$display("%0t: out_value mismatch at index %0d: expected %h, actual %h",
						$time, due.index, due.value, out_value);
					failures++;
				end
				if (out_last !== due.last) begin
					$display("%0t: out_last mismatch at index %0d: expected %b, actual %b",
						$time, due.index, due.last, out_last);
					failures++;
				end
			end
			results_checked++;
			if (out_last === 1'b1)
				vectors_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still due", $time,
				cycle_count, dot_products_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		layer_step_t s;
		int i;
		int r;
		int n;
		int pick;
		int target;
		for (i = 0; i < IN_LEN; i++)
			row_written[i] = '0;
		for (i = 0; i < OUT_LEN; i++)
			accum[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_STEPS; i++) begin
			s = layer_steps[i];
			case (s.op)
				OP_ROW_FILL: fill_row(s.row, 1'b0, s.value);
				OP_WEIGHT:   send_item(KIND_WEIGHT, s.row, s.col, s.value, 1'b0, '0);
				OP_ACT:      send_item(KIND_ACT, s.row, s.col, s.value, s.fixed, s.fixed_value);
				default:     ;
			endcase
		end

		target = item_count + RANDOM_ITEMS;
		while (item_count < target) begin
			quiet = (item_count >= target - RANDOM_ITEMS + QUIET_AFTER);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				fill_row(IDX_W'($urandom_range(0, IN_LEN - 1)), 1'b1, '0);
			end else if (pick < 35) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_item(KIND_WEIGHT, IDX_W'($urandom), IDX_W'($urandom), rand_word(),
						1'b0, '0);
			end else if (pick < 85) begin
				// full vector: ascending over written rows, some skipped, some repeated
				for (r = 0; r < IN_LEN - 1; r++) begin
					if (row_full(r)) begin
						n = $urandom_range(0, 19);
						if (n >= 3)
							send_item(KIND_ACT, IDX_W'(r), IDX_W'($urandom), rand_word(),
								1'b0, '0);
						if (n < 2)
							repeat (2) send_item(KIND_ACT, IDX_W'(r), IDX_W'($urandom),
								rand_word(), 1'b0, '0);
					end
				end
				send_item(KIND_ACT, IDX_W'(IN_LEN - 1), IDX_W'($urandom), rand_word(), 1'b0, '0);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					r = $urandom_range(0, IN_LEN - 1);
					if (!row_full(r))
						r = IN_LEN - 1;
					send_item(KIND_ACT, IDX_W'(r), IDX_W'($urandom), rand_word(), 1'b0, '0);
				end
			end
		end
		valid <= 1'b0;

		while (dot_products_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions; checked %0d output elements in %0d vectors.",
			item_count, results_checked, vectors_seen);
		$display("Covered value extremes, wrapping products, skipped and repeated rows.");
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/vmm_pkg.sv
sv/vmm_ram.sv
sv/vmm_ctrl.sv
sv/vmm_datapath.sv
sv/vector_matrix_multiply_int32.sv
sv/vmm_checker.sv
verif/tb_vector_matrix_multiply_int32.sv
